// ----- rtl/icu_pkg.sv -----
// Package with shared types, codes and constants of the integer calculator unit.
package icu_pkg;

    localparam int DataWidthDefault = 32;
    localparam int FuncWidth = 3;
    localparam int StatusWidth = 2;

    typedef enum logic [FuncWidth-1:0] {
        FUNC_SUB  = 3'd0,
        FUNC_DIV  = 3'd1,
        FUNC_REM  = 3'd2,
        FUNC_GCD  = 3'd3,
        FUNC_LCM  = 3'd4,
        FUNC_FACT = 3'd5
    } func_t;

    typedef enum logic [StatusWidth-1:0] {
        ST_OK      = 2'd0,
        ST_DIV0    = 2'd1,
        ST_BADCODE = 2'd2
    } status_t;

    typedef struct packed {
        logic [FuncWidth-1:0] func;
        logic signed [DataWidthDefault-1:0] operand_a;
        logic signed [DataWidthDefault-1:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic signed [DataWidthDefault-1:0] result;
        logic [StatusWidth-1:0] status;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_RUN,
        S_DIV_FIN,
        S_GCD_CHECK,
        S_LCM_MUL,
        S_FACT_STEP,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic do_sub;
        logic div_start;
        logic div_step;
        logic div_fin;
        logic gcd_shift;
        logic take_a;
        logic lcm_mul;
        logic lcm_setup;
        logic fact_step;
        logic set_one;
        logic set_zero;
        logic [StatusWidth-1:0] status;
        logic set_status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic b_zero;
        logic div_last;
        logic fact_small;
        logic fact_end;
        logic res_zero;
    } stat_t;

endpackage

// ----- rtl/icu_datapath.sv -----
// Datapath of the integer calculator: operand registers, shift-subtract divider, multiplier.
module icu_datapath import icu_pkg::*; #(
    parameter int DATA_WIDTH = DataWidthDefault
) (
    input  logic                  aclk,
    input  logic [FuncWidth-1:0]  func,
    input  logic [DATA_WIDTH-1:0] in_a,
    input  logic [DATA_WIDTH-1:0] in_b,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output logic [DATA_WIDTH-1:0] result,
    output logic [StatusWidth-1:0] status
);
    localparam int CntWidth = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [DATA_WIDTH-1:0] q_reg, q_next;
    logic [DATA_WIDTH-1:0] r_reg, r_next;
    logic [DATA_WIDTH-1:0] dm_reg, dm_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    logic [DATA_WIDTH-1:0] prod_reg, prod_next;
    logic [DATA_WIDTH-1:0] i_reg, i_next;
    logic [CntWidth-1:0]   cnt_reg, cnt_next;
    logic                  qneg_reg, qneg_next;
    logic                  rneg_reg, rneg_next;
    logic [StatusWidth-1:0] st_reg, st_next;

    logic [DATA_WIDTH-1:0] mag_a, mag_b, rsh, quot, rem;
    logic [DATA_WIDTH:0]   diff;

    assign mag_a = a_reg[DATA_WIDTH-1] ? (~a_reg + 1'b1) : a_reg;
    assign mag_b = b_reg[DATA_WIDTH-1] ? (~b_reg + 1'b1) : b_reg;
    assign rsh   = {r_reg[DATA_WIDTH-2:0], q_reg[DATA_WIDTH-1]};
    assign diff  = {1'b0, rsh} - {1'b0, dm_reg};
    assign quot  = qneg_reg ? (~q_reg + 1'b1) : q_reg;
    assign rem   = rneg_reg ? (~r_reg + 1'b1) : r_reg;

    assign stat.b_zero     = (b_reg == '0);
    assign stat.div_last   = (cnt_reg == CntWidth'(1));
    assign stat.fact_small = a_reg[DATA_WIDTH-1] || (a_reg < DATA_WIDTH'(2));
    assign stat.fact_end   = (i_reg == a_reg);
    assign stat.res_zero   = (res_reg == '0);

    always_comb begin
        a_next = a_reg; b_next = b_reg; q_next = q_reg; r_next = r_reg;
        dm_next = dm_reg; res_next = res_reg; prod_next = prod_reg;
        i_next = i_reg; cnt_next = cnt_reg; qneg_next = qneg_reg;
        rneg_next = rneg_reg; st_next = st_reg;
        if (cmd.load) begin
            a_next = in_a;
            b_next = in_b;
        end
        if (cmd.do_sub) res_next = a_reg - b_reg;
        if (cmd.div_start) begin
            q_next    = mag_a;
            r_next    = '0;
            dm_next   = mag_b;
            cnt_next  = CntWidth'(DATA_WIDTH);
            qneg_next = a_reg[DATA_WIDTH-1] ^ b_reg[DATA_WIDTH-1];
            rneg_next = a_reg[DATA_WIDTH-1];
        end
        if (cmd.div_step) begin
            if (!diff[DATA_WIDTH]) begin
                r_next = diff[DATA_WIDTH-1:0];
                q_next = {q_reg[DATA_WIDTH-2:0], 1'b1};
            end else begin
                r_next = rsh;
                q_next = {q_reg[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.div_fin) begin
            priority case (func)
                FUNC_DIV, FUNC_LCM: res_next = quot;
                default:            res_next = rem;
            endcase
        end
        // Euclid step: (a, b) <= (b, a rem b); the remainder is in rem.
        if (cmd.gcd_shift) begin
            a_next = b_reg;
            b_next = rem;
        end
        // Once b reaches zero, a holds the gcd.
        if (cmd.take_a) res_next = a_reg;
        if (cmd.lcm_mul) prod_next = DATA_WIDTH'(in_a * in_b);
        // Divide the wrapped product by the gcd now held in a.
        if (cmd.lcm_setup) begin
            b_next = a_reg;
            a_next = prod_reg;
        end
        if (cmd.fact_step) begin
            res_next = DATA_WIDTH'(res_reg * (i_reg + 1'b1));
            i_next   = i_reg + 1'b1;
        end
        if (cmd.set_one) begin
            res_next = DATA_WIDTH'(1);
            i_next   = DATA_WIDTH'(1);
        end
        if (cmd.set_zero) res_next = '0;
        if (cmd.set_status) st_next = cmd.status;
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next; b_reg <= b_next; q_reg <= q_next; r_reg <= r_next;
        dm_reg <= dm_next; res_reg <= res_next; prod_reg <= prod_next;
        i_reg <= i_next; cnt_reg <= cnt_next; qneg_reg <= qneg_next;
        rneg_reg <= rneg_next; st_reg <= st_next;
    end

    assign result = res_reg;
    assign status = st_reg;
endmodule

// ----- rtl/icu_ctrl.sv -----
// Controller state machine of the integer calculator.
module icu_ctrl import icu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  logic [FuncWidth-1:0] func,
    input  stat_t                stat,
    output cmd_t                 cmd
);
    state_t state_reg, state_next;
    logic   lcm_div_reg, lcm_div_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            lcm_div_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lcm_div_reg <= lcm_div_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        lcm_div_next = lcm_div_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                lcm_div_next = 1'b0;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status = ST_OK;
                    priority case (func)
                        FUNC_SUB: state_next = S_DONE;
                        FUNC_DIV, FUNC_REM: state_next = S_DIV_START;
                        FUNC_GCD: state_next = S_GCD_CHECK;
                        FUNC_LCM: begin
                            cmd.lcm_mul = 1'b1;
                            state_next = S_GCD_CHECK;
                        end
                        FUNC_FACT: state_next = S_FACT_STEP;
                        default: begin
                            cmd.status = ST_BADCODE;
                            cmd.set_zero = 1'b1;
                            state_next = S_DONE;
                        end
                    endcase
                    if (func == FUNC_SUB) state_next = S_LCM_MUL;
                    if (func == FUNC_FACT) cmd.set_one = 1'b1;
                end
            end
            // For subtract, this state just forms a - b once operands are loaded.
            S_LCM_MUL: begin
                if (func == FUNC_SUB) begin
                    cmd.do_sub = 1'b1;
                end else begin
                    cmd.lcm_setup = 1'b1;
                    lcm_div_next = 1'b1;
                end
                state_next = (func == FUNC_SUB) ? S_DONE : S_DIV_START;
            end
            S_DIV_START: begin
                if (stat.b_zero) begin
                    cmd.set_zero = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status = ST_DIV0;
                    state_next = S_DONE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV_RUN;
                end
            end
            S_DIV_RUN: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) state_next = S_DIV_FIN;
            end
            // For lcm, the division after the Euclid loop is the final one.
            S_DIV_FIN: begin
                if (func == FUNC_GCD || (func == FUNC_LCM && !lcm_div_reg)) begin
                    cmd.gcd_shift = 1'b1;
                    state_next = S_GCD_CHECK;
                end else begin
                    cmd.div_fin = 1'b1;
                    state_next = S_DONE;
                end
            end
            // Loop test of Euclid; b_zero here means a holds the gcd.
            S_GCD_CHECK: begin
                if (stat.b_zero) begin
                    if (func == FUNC_GCD) begin
                        cmd.take_a = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_LCM_MUL;
                    end
                end else begin
                    state_next = S_DIV_START;
                end
            end
            S_FACT_STEP: begin
                if (stat.fact_small || stat.fact_end || stat.res_zero) begin
                    state_next = S_DONE;
                end else begin
                    cmd.fact_step = 1'b1;
                end
            end
            S_DONE: begin
                out_valid = 1'b1;
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ----- rtl/integer_calculator_unit.sv -----
// Subtract forms a - b directly; divide/remainder make one pass of the shift-subtract divider;
// gcd and lcm make one division per Euclid step, plus a final division for lcm; factorial
// takes one multiply per factor. One transaction at a time: a new input is taken only
// after the last result has been taken.
// The result waits in the output register until taken.
// Reset: aresetn synchronous, active low; returns the controller to idle.
module integer_calculator_unit import icu_pkg::*; #(
    parameter int DATA_WIDTH = DataWidthDefault
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);
    cmd_t  cmd;
    stat_t stat;
    logic [FuncWidth-1:0] func_reg;
    logic [DATA_WIDTH-1:0] res;
    logic [StatusWidth-1:0] st;
    logic [FuncWidth-1:0] func_sel;

    assign func_sel = (s_valid && s_ready) ? s_data.func : func_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) func_reg <= s_data.func;
    end

    icu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .out_valid(m_valid), .out_ready(m_ready),
        .func(func_sel), .stat(stat), .cmd(cmd)
    );

    icu_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .aclk(aclk), .func(func_reg),
        .in_a(DATA_WIDTH'(s_data.operand_a)), .in_b(DATA_WIDTH'(s_data.operand_b)),
        .cmd(cmd), .stat(stat), .result(res), .status(st)
    );

    assign m_data.result = DataWidthDefault'(res);
    assign m_data.status = st;
endmodule

// ----- rtl/icu_checker.sv -----
// Port-level checker for the integer calculator unit, with its bind.
module icu_checker import icu_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.result == '0)
        else $error("nonzero result with error status");
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3) else $error("invalid status code");
endmodule

bind integer_calculator_unit icu_checker u_icu_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
